// ===== hdl/assert_macros.svh =====
// assertion helpers, sampled on the rising clock edge and quiet during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/rgd_pkg.sv =====
package rgd_pkg;

   localparam int MAX_WIDTH_DEF  = 512;
   localparam int MAX_HEIGHT_DEF = 256;

   // register widths
   localparam int WIDTH_REG_W  = 10;
   localparam int HEIGHT_REG_W = 9;
   localparam int BRIGHT_W     = 7;
   localparam int CSR_DATA_W   = 10;
   localparam int CSR_INDEX_W  = 2;

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 10'd512;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 9'd256;
   localparam logic [BRIGHT_W-1:0]     BRIGHT_RESET = 7'd100;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH    = 2'd0,
      CSR_IMAGE_HEIGHT   = 2'd1,
      CSR_DITHER_ENABLE  = 2'd2,
      CSR_BRIGHTNESS     = 2'd3
   } csr_index_type;

   // datapath widths
   localparam int NUM_CH  = 3;
   localparam int CH_B    = 0;
   localparam int CH_G    = 1;
   localparam int CH_R    = 2;
   localparam int CHAN_W  = 8;
   localparam int ERR_W   = 6;
   localparam int Q_W     = 5;
   localparam int PROD_W  = CHAN_W + BRIGHT_W;
   localparam int WORD_W  = 16;
   localparam int COL_W   = 9;
   localparam int SROW_W  = 8;

   // (v*32*b/100)>>8 == v*b/800, done as a multiply by a rounded-up reciprocal
   localparam int SCALE_DIV   = 800;
   localparam int RECIP_SHIFT = 25;
   localparam int RECIP_W     = 16;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'((2 ** RECIP_SHIFT + SCALE_DIV - 1) / SCALE_DIV);

   typedef logic [NUM_CH-1:0][ERR_W-1:0] err3_type;

   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } req_payload_type;

   typedef struct packed {
      logic [WORD_W-1:0] pixel_word;
      logic [COL_W-1:0]  column;
      logic [SROW_W-1:0] screen_row;
      logic              last_pixel;
   } rsp_payload_type;

   typedef struct packed {
      logic enable;
      logic use_below;
      logic col_first;
   } dith_ctl_type;

   typedef struct packed {
      logic [CHAN_W-1:0] v;
      logic [ERR_W-1:0]  e3;
      logic [ERR_W-1:0]  e5;
      logic [ERR_W-1:0]  e7;
   } dith_out_type;

endpackage

// ===== hdl/rgd_stream_if.sv =====
interface rgd_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/rgd_err_diff.sv =====
module rgd_err_diff import rgd_pkg::*; (
   input  dith_ctl_type       ctl,
   input  logic [CHAN_W-1:0]  pixel,
   input  logic [ERR_W-1:0]   right_err,
   input  logic [ERR_W-1:0]   below_err,
   output dith_out_type       res
);

   logic [ERR_W:0]    add;
   logic [CHAN_W:0]   sum;
   logic [CHAN_W-1:0] v;
   logic [2:0]        e;
   logic [4:0]        e_x3;
   logic [5:0]        e_x5;
   logic [5:0]        e_x7;

   always_comb begin
      add = (ctl.col_first ? '0 : {1'b0, right_err})
          + (ctl.use_below ? {1'b0, below_err} : '0);
      sum = {1'b0, pixel} + (CHAN_W + 1)'(add);
      // sum stays below 512, so the top bit alone means above 255
      if (!ctl.enable) begin
         v = pixel;
      end else if (sum[CHAN_W]) begin
         v = '1;
      end else begin
         v = sum[CHAN_W-1:0];
      end

      // truncation error is what the 5-bit level drops
      e = ctl.enable ? v[2:0] : 3'd0;
      e_x3 = {2'b00, e} + {1'b0, e, 1'b0};
      e_x5 = {3'b000, e} + {1'b0, e, 2'b00};
      e_x7 = {e, 3'b000} - {3'b000, e};

      // weights over 16; the 1/16 share of a 3-bit error is always zero
      res.v  = v;
      res.e3 = ERR_W'(e_x3[4]);
      res.e5 = ERR_W'(e_x5[5:4]);
      res.e7 = ERR_W'(e_x7[5:4]);
   end

endmodule

// ===== hdl/rgd_scale.sv =====
module rgd_scale import rgd_pkg::*; (
   input  logic [PROD_W-1:0] prod,
   output logic [Q_W-1:0]    level
);

   localparam int FULL_W = PROD_W + RECIP_W;
   localparam int QUO_W  = FULL_W - RECIP_SHIFT;

   logic [FULL_W-1:0] full;
   logic [QUO_W-1:0]  quo;

   always_comb begin
      full = FULL_W'(prod) * FULL_W'(RECIP);
      quo  = full[FULL_W-1:RECIP_SHIFT];
      // brightness above 100 can push the level past 31
      level = (quo[QUO_W-1:Q_W] != '0) ? '1 : quo[Q_W-1:0];
   end

endmodule

// ===== hdl/rgb888_to_grb555_dither_top.sv =====
// channel      dir  handshake        payload
// req_stream   in   valid / ready    blue, green, red
// rsp_stream   out  valid / ready    pixel_word, column, screen_row, last_pixel
// csr_*        in   write enable     index, write data (no read-back)
//
// one request per cycle unless results stall or the line clear runs; registers:
// stage 1 (line memory read), stage 2 (error diffusion and brightness multiply),
// result (scale); the right-neighbor error loop closes inside the middle stage, so
// it sets the rate; after reset every line memory word is cleared with req ready
// low; a stalled result fills the three stage registers before req ready drops
`include "assert_macros.svh"

module rgb888_to_grb555_dither_top import rgd_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   rgd_stream_if.sink             req_stream,
   rgd_stream_if.source           rsp_stream,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int XW = (CW + 1 > WIDTH_REG_W) ? CW + 1 : WIDTH_REG_W;
   localparam int YW = (RW + 1 > HEIGHT_REG_W) ? RW + 1 : HEIGHT_REG_W;

   // configuration
   logic [WIDTH_REG_W-1:0]  width_ff;
   logic [HEIGHT_REG_W-1:0] height_ff;
   logic                    dith_ff;
   logic [BRIGHT_W-1:0]     bright_ff;
   logic [XW-1:0]           w_eff;
   logic [YW-1:0]           h_eff;

   // position counters
   logic [CW-1:0] col_ff;
   logic [CW-1:0] col_in;
   logic [RW-1:0] row_ff;
   logic [RW-1:0] row_in;
   logic [CW-1:0] col0;
   logic [RW-1:0] row0;
   logic          row_wrap;
   logic          col_last;
   logic          row_last;
   logic [YW-1:0] srow_full;

   // handshake
   logic req_ready;
   logic req_acc;
   logic out_go;
   logic s2_take;
   logic s1_take;
   logic s1_go;

   // stage 1
   logic              s1_v_ff;
   req_payload_type   s1_pix_ff;
   logic [CW-1:0]     s1_col_ff;
   logic              s1_col_first_ff;
   logic              s1_col_last_ff;
   logic              s1_row_first_ff;
   logic [SROW_W-1:0] s1_srow_ff;
   logic              s1_last_ff;
   err3_type          rd_ff;
   err3_type          right_ff;
   err3_type          pend_ff;
   logic [NUM_CH-1:0][CHAN_W-1:0] pix_ch;
   dith_ctl_type      ctl;
   dith_out_type      dres [NUM_CH];
   err3_type          norm_data;
   err3_type          pend_new;
   err3_type          right_new;

   // line memory and its write port
   err3_type      line_mem_ff [MAX_WIDTH];
   logic          clr_active_ff;
   logic [CW-1:0] clr_addr_ff;
   logic          def_v_ff;
   logic [CW-1:0] def_addr_ff;
   err3_type      def_data_ff;
   logic          def_written;
   logic          norm_we;
   logic [CW-1:0] norm_addr;
   logic          mem_we;
   logic [CW-1:0] mem_addr;
   err3_type      mem_data;
   logic          rd_hit_last;
   logic          rd_hit_norm;
   logic          rd_hit_def;

   // stage 2 and result
   logic                          s2_v_ff;
   logic [NUM_CH-1:0][PROD_W-1:0] s2_prod_ff;
   logic [CW-1:0]                 s2_col_ff;
   logic [SROW_W-1:0]             s2_srow_ff;
   logic                          s2_last_ff;
   logic [NUM_CH-1:0][Q_W-1:0]    q;
   logic [WORD_W-1:0]             word;
   logic [XW-1:0]                 s2_col_x;
   logic                          rsp_v_ff;
   rsp_payload_type               rsp_pay_ff;

   // effective image size
   always_comb begin
      w_eff = XW'(width_ff);
      if (width_ff == '0) begin
         w_eff = XW'(1);
      end else if (XW'(width_ff) > XW'(MAX_WIDTH)) begin
         w_eff = XW'(MAX_WIDTH);
      end
      h_eff = YW'(height_ff);
      if (height_ff == '0) begin
         h_eff = YW'(1);
      end else if (YW'(height_ff) > YW'(MAX_HEIGHT)) begin
         h_eff = YW'(MAX_HEIGHT);
      end
   end

   // position of the incoming request, with restart when the size shrank
   always_comb begin
      row_wrap  = YW'(row_ff) >= h_eff;
      row0      = row_wrap ? '0 : row_ff;
      col0      = (row_wrap || (XW'(col_ff) >= w_eff)) ? '0 : col_ff;
      col_last  = XW'(col0) == (w_eff - XW'(1));
      row_last  = YW'(row0) == (h_eff - YW'(1));
      srow_full = h_eff - YW'(1) - YW'(row0);
      if (col_last) begin
         col_in = '0;
         row_in = row_last ? '0 : row0 + RW'(1);
      end else begin
         col_in = col0 + CW'(1);
         row_in = row0;
      end
   end

   assign out_go    = !rsp_v_ff || rsp_stream.ready;
   assign s2_take   = !s2_v_ff || out_go;
   assign s1_take   = !s1_v_ff || s2_take;
   assign s1_go     = s1_v_ff && s2_take;
   assign req_ready = s1_take && !clr_active_ff;
   assign req_acc   = req_stream.valid && req_ready;

   assign req_stream.ready   = req_ready;
   assign rsp_stream.valid   = rsp_v_ff;
   assign rsp_stream.payload = rsp_pay_ff;

   // error diffusion, one slice per color
   assign pix_ch[CH_B] = s1_pix_ff.blue;
   assign pix_ch[CH_G] = s1_pix_ff.green;
   assign pix_ch[CH_R] = s1_pix_ff.red;

   always_comb begin
      ctl.enable    = dith_ff;
      ctl.use_below = !s1_row_first_ff;
      ctl.col_first = s1_col_first_ff;
   end

   for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_ch
      rgd_err_diff u_err_diff (
         .ctl       (ctl),
         .pixel     (pix_ch[ch]),
         .right_err (right_ff[ch]),
         .below_err (rd_ff[ch]),
         .res       (dres[ch])
      );

      always_comb begin
         norm_data[ch] = (s1_col_first_ff ? '0 : pend_ff[ch]) + dres[ch].e3;
         pend_new[ch]  = dres[ch].e5;
         right_new[ch] = s1_col_last_ff ? '0 : dres[ch].e7;
      end

      rgd_scale u_scale (
         .prod  (s2_prod_ff[ch]),
         .level (q[ch])
      );
   end

   // line memory write port: clearing pass, lower-left write, then the held
   // write of the last column of a row
   always_comb begin
      norm_we     = s1_go && !s1_col_first_ff;
      norm_addr   = s1_col_ff - CW'(1);
      def_written = def_v_ff && !norm_we && !clr_active_ff;
      mem_we      = 1'b1;
      if (clr_active_ff) begin
         mem_addr = clr_addr_ff;
         mem_data = '0;
      end else if (norm_we) begin
         mem_addr = norm_addr;
         mem_data = norm_data;
      end else begin
         mem_we   = def_v_ff;
         mem_addr = def_addr_ff;
         mem_data = def_data_ff;
      end
      // forward writes that have not reached the array yet
      rd_hit_last = s1_go && s1_col_last_ff && (s1_col_ff == col0);
      rd_hit_norm = norm_we && (norm_addr == col0);
      rd_hit_def  = def_v_ff && (def_addr_ff == col0);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem_ff[mem_addr] <= mem_data;
      end
      if (req_acc) begin
         if (rd_hit_last) begin
            rd_ff <= pend_new;
         end else if (rd_hit_norm) begin
            rd_ff <= norm_data;
         end else if (rd_hit_def) begin
            rd_ff <= def_data_ff;
         end else begin
            rd_ff <= line_mem_ff[col0];
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= WIDTH_RESET;
         height_ff     <= HEIGHT_RESET;
         dith_ff       <= 1'b0;
         bright_ff     <= BRIGHT_RESET;
         col_ff        <= '0;
         row_ff        <= '0;
         s1_v_ff       <= 1'b0;
         s2_v_ff       <= 1'b0;
         rsp_v_ff      <= 1'b0;
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
         def_v_ff      <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_IMAGE_WIDTH:   width_ff  <= csr_write_data[WIDTH_REG_W-1:0];
               CSR_IMAGE_HEIGHT:  height_ff <= csr_write_data[HEIGHT_REG_W-1:0];
               CSR_DITHER_ENABLE: dith_ff   <= csr_write_data[0];
               CSR_BRIGHTNESS:    bright_ff <= csr_write_data[BRIGHT_W-1:0];
               default: ;
            endcase
         end
         if (req_acc) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (s1_take) begin
            s1_v_ff <= req_acc;
         end
         if (s2_take) begin
            s2_v_ff <= s1_v_ff;
         end
         if (out_go) begin
            rsp_v_ff <= s2_v_ff;
         end
         if (clr_active_ff) begin
            clr_addr_ff <= clr_addr_ff + CW'(1);
            if (clr_addr_ff == CW'(MAX_WIDTH - 1)) begin
               clr_active_ff <= 1'b0;
            end
         end
         if (s1_go && s1_col_last_ff) begin
            def_v_ff <= 1'b1;
         end else if (def_written) begin
            def_v_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_comb begin
      word     = {q[CH_G], q[CH_R], q[CH_B], 1'b0};
      word[0]  = |word;
      s2_col_x = XW'(s2_col_ff);
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_pix_ff       <= req_stream.payload;
         s1_col_ff       <= col0;
         s1_col_first_ff <= col0 == '0;
         s1_col_last_ff  <= col_last;
         s1_row_first_ff <= row0 == '0;
         s1_srow_ff      <= srow_full[SROW_W-1:0];
         s1_last_ff      <= col_last && row_last;
      end
      if (s1_go) begin
         right_ff   <= right_new;
         pend_ff    <= pend_new;
         s2_col_ff  <= s1_col_ff;
         s2_srow_ff <= s1_srow_ff;
         s2_last_ff <= s1_last_ff;
         for (int ch = 0; ch < NUM_CH; ch++) begin
            s2_prod_ff[ch] <= PROD_W'(dres[ch].v) * PROD_W'(bright_ff);
         end
      end
      if (s1_go && s1_col_last_ff) begin
         def_addr_ff <= s1_col_ff;
         def_data_ff <= pend_new;
      end
      if (out_go && s2_v_ff) begin
         rsp_pay_ff.pixel_word <= word;
         rsp_pay_ff.column     <= s2_col_x[COL_W-1:0];
         rsp_pay_ff.screen_row <= s2_srow_ff;
         rsp_pay_ff.last_pixel <= s2_last_ff;
      end
   end

   `ASSERT_IMPL(a_def_no_clash, def_v_ff, !norm_we, "held line write meets a column write")
   `ASSERT_IMPL(a_clear_len, $fell(clr_active_ff), $past(clr_addr_ff) == CW'(MAX_WIDTH - 1), "line clear ended early")
   `ASSERT_NEXT(a_s1_hold, s1_v_ff && !s2_take, s1_v_ff && $stable(s1_col_ff), "stage 1 lost a request")

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import rgd_pkg::*;

   localparam int MAX_W        = MAX_WIDTH_DEF;
   localparam int MAX_H        = MAX_HEIGHT_DEF;
   localparam int RANDOM_ITEMS = 650;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int REPORT_LIMIT = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   rgd_stream_if #(.payload_type(req_payload_type)) req_stream ();
   rgd_stream_if #(.payload_type(rsp_payload_type)) rsp_stream ();

   rgb888_to_grb555_dither_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_stream       (req_stream),
      .rsp_stream       (rsp_stream),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #10 clock = ~clock;

   // register copies
   logic [WIDTH_REG_W-1:0]  cfg_width;
   logic [HEIGHT_REG_W-1:0] cfg_height;
   logic                    cfg_dither;
   logic [BRIGHT_W-1:0]     cfg_bright;

   // diffusion state
   logic [ERR_W-1:0] below_err [NUM_CH][MAX_W];
   logic [ERR_W-1:0] right_err [NUM_CH];
   logic [ERR_W-1:0] pend_err  [NUM_CH];
   logic [ERR_W-1:0] carry_err [NUM_CH];
   int unsigned      col_cnt;
   int unsigned      row_cnt;

   req_payload_type pending_pixels [$];
   rsp_payload_type expected_pixels [$];
   int unsigned     queued_count;
   int unsigned     accepted_count;
   int unsigned     pixels_checked;
   int unsigned     mismatch_count;
   int unsigned     cycle_count;

   logic req_fire;
   logic rsp_fire;
   int   req_gap;
   int   req_burst;
   int   rsp_hold;
   int   rsp_burst;

   function automatic int unsigned clamp_dim(int unsigned v, int unsigned maxv);
      if (v < 1) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   function automatic void predict_pixel(req_payload_type px);
      int unsigned w, h, x, v, e, word;
      int unsigned q [NUM_CH];
      int unsigned chan [NUM_CH];
      rsp_payload_type exp_px;
      bit dith;
      w = clamp_dim(cfg_width, MAX_W);
      h = clamp_dim(cfg_height, MAX_H);
      dith = cfg_dither;
      chan[CH_B] = px.blue;
      chan[CH_G] = px.green;
      chan[CH_R] = px.red;
      // counters left beyond a shrunken image restart it
      if (row_cnt >= h) begin
         row_cnt = 0;
         col_cnt = 0;
      end
      if (col_cnt >= w) col_cnt = 0;
      if (col_cnt == 0) begin
         foreach (right_err[c]) begin
            right_err[c] = '0;
            pend_err[c]  = '0;
            carry_err[c] = '0;
         end
      end
      x = col_cnt;
      for (int c = 0; c < NUM_CH; c++) begin
         v = chan[c];
         if (dith) begin
            v = v + right_err[c];
            // line store is stale on the first row
            if (row_cnt > 0) v = v + below_err[c][x];
            if (v > 255) v = 255;
         end
         q[c] = ((v * 32 * cfg_bright) / 100) >> 8;
         if (q[c] > 31) q[c] = 31;
         e = dith ? v - (v & 'hf8) : 0;
         if (x > 0) below_err[c][x - 1] = ERR_W'(pend_err[c] + ((e * 3) >> 4));
         pend_err[c] = ERR_W'(carry_err[c] + ((e * 5) >> 4));
         if (x + 1 < w) begin
            carry_err[c] = ERR_W'(e >> 4);
            right_err[c] = ERR_W'((e * 7) >> 4);
         end else begin
            carry_err[c] = '0;
            right_err[c] = '0;
            below_err[c][x] = pend_err[c];
         end
      end
      word = (q[CH_G] << 11) | (q[CH_R] << 6) | (q[CH_B] << 1);
      if (word != 0) word = word | 1;
      exp_px.pixel_word = WORD_W'(word);
      exp_px.column     = COL_W'(x);
      exp_px.screen_row = SROW_W'(h - 1 - row_cnt);
      exp_px.last_pixel = (x == w - 1) && (row_cnt == h - 1);
      expected_pixels.push_back(exp_px);
      col_cnt++;
      if (col_cnt >= w) begin
         col_cnt = 0;
         row_cnt++;
         if (row_cnt >= h) row_cnt = 0;
      end
   endfunction

   function automatic void note_mismatch(string what, int unsigned want, int unsigned got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("pixel %0d: %0s expected 0x%0h got 0x%0h", pixels_checked, what, want, got);
   endfunction

   function automatic void check_pixel(rsp_payload_type got);
      rsp_payload_type want;
      if (expected_pixels.size() == 0) begin
         note_mismatch("unrequested pixel_word", 0, got.pixel_word);
         return;
      end
      want = expected_pixels.pop_front();
      if (got.pixel_word !== want.pixel_word)
         note_mismatch("pixel_word", want.pixel_word, got.pixel_word);
      if (got.column !== want.column)
         note_mismatch("column", want.column, got.column);
      if (got.screen_row !== want.screen_row)
         note_mismatch("screen_row", want.screen_row, got.screen_row);
      if (got.last_pixel !== want.last_pixel)
         note_mismatch("last_pixel", want.last_pixel, got.last_pixel);
      pixels_checked++;
   endfunction

   // mostly a uniform random wait, now and then a run of back-to-back transfers
   function automatic int draw_wait(inout int burst);
      if (burst > 0) begin
         burst--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         burst = $urandom_range(8, 40);
         return 0;
      end
      return $urandom_range(0, 18);
   endfunction

   function automatic logic [CHAN_W-1:0] rand_chan();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hff;
         2: return CHAN_W'($urandom_range(0, 31) * 8 + 7);
         default: return CHAN_W'($urandom);
      endcase
   endfunction

   function automatic void queue_pixel(logic [CHAN_W-1:0] b, logic [CHAN_W-1:0] g,
                                       logic [CHAN_W-1:0] r);
      req_payload_type px;
      px.blue  = b;
      px.green = g;
      px.red   = r;
      pending_pixels.push_back(px);
      queued_count++;
   endfunction

   function automatic void queue_noise(int n);
      repeat (n) queue_pixel(rand_chan(), rand_chan(), rand_chan());
   endfunction

   task automatic wait_idle();
      while (accepted_count != queued_count || expected_pixels.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, int unsigned data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= CSR_DATA_W'(data);
      case (idx)
         CSR_IMAGE_WIDTH:   cfg_width  = WIDTH_REG_W'(data);
         CSR_IMAGE_HEIGHT:  cfg_height = HEIGHT_REG_W'(data);
         CSR_DITHER_ENABLE: cfg_dither = data[0];
         CSR_BRIGHTNESS:    cfg_bright = BRIGHT_W'(data);
         default: ;
      endcase
   endtask

   task automatic reconfigure(int unsigned w, int unsigned h, int unsigned d, int unsigned b);
      wait_idle();
      // let the pipeline drain fully
      repeat (6) @(negedge clock);
      write_reg(CSR_IMAGE_WIDTH, w);
      write_reg(CSR_IMAGE_HEIGHT, h);
      write_reg(CSR_DITHER_ENABLE, d);
      write_reg(CSR_BRIGHTNESS, b);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_stream.valid <= 1'b0;
      end else if (!req_stream.valid || req_fire) begin
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_stream.valid <= 1'b0;
         end else if (pending_pixels.size() != 0) begin
            req_stream.payload <= pending_pixels.pop_front();
            req_stream.valid   <= 1'b1;
            req_gap            <= draw_wait(req_burst);
         end else begin
            req_stream.valid <= 1'b0;
         end
      end
   end

   // result back-pressure
   always @(negedge clock) begin : rsp_backpressure
      int stall;
      if (reset) begin
         rsp_stream.ready <= 1'b0;
         rsp_hold <= 0;
      end else if (rsp_fire) begin
         stall = draw_wait(rsp_burst);
         rsp_hold <= stall;
         rsp_stream.ready <= (stall == 0);
      end else if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_stream.ready <= (rsp_hold == 1);
      end else begin
         rsp_stream.ready <= 1'b1;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
         rsp_fire <= 1'b0;
      end else begin
         req_fire <= req_stream.valid && req_stream.ready;
         rsp_fire <= rsp_stream.valid && rsp_stream.ready;
         if (req_stream.valid && req_stream.ready) begin
            predict_pixel(req_stream.payload);
            accepted_count++;
         end
         if (rsp_stream.valid && rsp_stream.ready) check_pixel(rsp_stream.payload);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      int unsigned w_pick, h_pick, b_pick, n, random_count;
      req_stream.valid   = 1'b0;
      req_stream.payload = '0;
      rsp_stream.ready   = 1'b0;
      csr_write_enable   = 1'b0;
      csr_index          = CSR_IMAGE_WIDTH;
      csr_write_data     = '0;
      cfg_width      = WIDTH_RESET;
      cfg_height     = HEIGHT_RESET;
      cfg_dither     = 1'b0;
      cfg_bright     = BRIGHT_RESET;
      foreach (below_err[c, x]) below_err[c][x] = '0;
      foreach (right_err[c]) begin
         right_err[c] = '0;
         pend_err[c]  = '0;
         carry_err[c] = '0;
      end
      col_cnt        = 0;
      row_cnt        = 0;
      queued_count   = 0;
      accepted_count = 0;
      pixels_checked = 0;
      mismatch_count = 0;
      cycle_count    = 0;
      req_fire       = 1'b0;
      rsp_fire       = 1'b0;
      req_gap        = 0;
      req_burst      = 0;
      rsp_hold       = 0;
      rsp_burst      = 0;
      random_count   = 0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: wide image, bottom row lands on screen row 255
      queue_pixel(8'h00, 8'h00, 8'h00);
      queue_pixel(8'hff, 8'hff, 8'hff);
      queue_pixel(8'h01, 8'h80, 8'h7f);

      // plain truncation, one channel at a time, then the last pixel
      reconfigure(3, 2, 0, 100);
      queue_pixel(8'hff, 8'h00, 8'h00);
      queue_pixel(8'h00, 8'hff, 8'h00);
      queue_pixel(8'h00, 8'h00, 8'hff);
      queue_pixel(8'h07, 8'h07, 8'h07);
      queue_pixel(8'h08, 8'h08, 8'h08);
      queue_pixel(8'hff, 8'hff, 8'hff);

      // diffusion with maximum truncation error, brightness saturating
      reconfigure(3, 2, 1, 127);
      queue_pixel(8'hff, 8'hff, 8'hff);
      queue_pixel(8'hf7, 8'h07, 8'h8f);
      queue_pixel(8'h07, 8'hf7, 8'h0f);
      queue_pixel(8'hfe, 8'h37, 8'h77);
      queue_pixel(8'h07, 8'h07, 8'h07);
      queue_pixel(8'h00, 8'hff, 8'h00);

      // zero sizes act as one pixel, zero brightness
      reconfigure(0, 0, 1, 0);
      queue_pixel(8'hff, 8'hff, 8'hff);
      queue_pixel(8'h17, 8'h27, 8'h37);

      // oversize registers clamp to the line store width and the maximum height
      reconfigure(1023, 511, 0, 1);
      queue_pixel(8'hff, 8'hff, 8'hff);
      queue_pixel(8'h80, 8'h40, 8'h20);

      while (random_count < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0: w_pick = 1;
            1: w_pick = 2;
            2: w_pick = $urandom_range(3, 8);
            6: w_pick = 0;
            7: w_pick = MAX_W;
            8: w_pick = $urandom_range(MAX_W + 1, 1023);
            9: w_pick = $urandom_range(1, MAX_W);
            default: w_pick = $urandom_range(4, 24);
         endcase
         case ($urandom_range(0, 9))
            0: h_pick = 0;
            1: h_pick = 1;
            7: h_pick = MAX_H;
            8: h_pick = $urandom_range(MAX_H + 1, 511);
            9: h_pick = $urandom_range(1, MAX_H);
            default: h_pick = $urandom_range(2, 6);
         endcase
         case ($urandom_range(0, 7))
            0: b_pick = 0;
            1: b_pick = 100;
            2: b_pick = 127;
            3: b_pick = $urandom_range(101, 127);
            default: b_pick = $urandom_range(0, 100);
         endcase
         // counters are not cleared here, so a smaller image may restart mid-row
         reconfigure(w_pick, h_pick, ($urandom_range(0, 3) != 0), b_pick);
         n = $urandom_range(40, 90);
         queue_noise(n);
         random_count += n;
      end

      wait_idle();
      repeat (8) @(negedge clock);
      if (mismatch_count == 0 && expected_pixels.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/rgd_pkg.sv
hdl/rgd_stream_if.sv
hdl/rgd_err_diff.sv
hdl/rgd_scale.sv
hdl/rgb888_to_grb555_dither_top.sv
sim/tb.sv
